### src/srrm_pkg.sv
// ----------------------------------------------------------------------------
// srrm_pkg
// Shared types, codes and defaults of the scrollback ring row mapper.
// ----------------------------------------------------------------------------
package srrm_pkg;

  localparam int RING_ROWS_DEF = 4096;

  localparam int MODE_W   = 3;
  localparam int DELTA_W  = 32;
  localparam int SROW_W   = 8;
  localparam int VIS_W    = 9;
  localparam int HLIM_W   = 12;
  localparam int LW_W     = 10;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 2;
  localparam int OROW_W   = 12;
  localparam int CELL_W   = 21;
  localparam int OCNT_W   = 12;
  localparam int CODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SCROLL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIVE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [CIDX_W-1:0] REG_VIS  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HLIM = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LW   = 2'd2;

  localparam logic [CODE_W-1:0] WIPE_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] WIPE_ROW   = 2'd1;
  localparam logic [CODE_W-1:0] WIPE_STORE = 2'd2;

  localparam logic [CODE_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [CODE_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [CODE_W-1:0] STAT_NOVIS  = 2'd2;

  localparam logic [VIS_W-1:0]  VIS_RST  = 9'd24;
  localparam logic [HLIM_W-1:0] HLIM_RST = 12'd1000;
  localparam logic [LW_W-1:0]   LW_RST   = 10'd80;

  typedef struct packed {
    logic capture;
    logic fit;
    logic exec;
    logic mult;
  } srrm_cmd_t;

endpackage

### src/srrm_ctrl.sv
// ----------------------------------------------------------------------------
// srrm_ctrl
// Sequencer: capture, execute, multiply, and geometry fit after writes.
// ----------------------------------------------------------------------------
module srrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cfg_we,
  output logic               busy,
  output logic               out_valid,
  output srrm_pkg::srrm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIT  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_MULT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
          pend_nxt    = cfg_we;
        end else if (cfg_we) begin
          state_nxt = ST_FIT;
        end
      end
      ST_FIT: begin
        cmd.fit = 1'b1;
        if (!cfg_we) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = ST_MULT;
        pend_nxt  = pend_r | cfg_we;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = (pend_r || cfg_we) ? ST_FIT : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FIT;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

### src/srrm_datapath.sv
// ----------------------------------------------------------------------------
// srrm_datapath
// Config registers, ring geometry, ring counters and result registers.
// ----------------------------------------------------------------------------
module srrm_datapath #(
  parameter int RING_ROWS = srrm_pkg::RING_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srrm_pkg::srrm_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [srrm_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [srrm_pkg::CFG_W-1:0]        cfg_data,
  input  logic [srrm_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [srrm_pkg::DELTA_W-1:0] in_scroll_delta,
  input  logic [srrm_pkg::SROW_W-1:0]       in_screen_row,
  output logic [srrm_pkg::OROW_W-1:0]       out_ring_row,
  output logic [srrm_pkg::CELL_W-1:0]       out_cell_base,
  output logic [srrm_pkg::OCNT_W-1:0]       out_view_offset,
  output logic [srrm_pkg::OCNT_W-1:0]       out_history_lines,
  output logic [srrm_pkg::CODE_W-1:0]       out_wipe,
  output logic [srrm_pkg::CODE_W-1:0]       out_status
);

  localparam int CW = $clog2(RING_ROWS + 1);
  localparam int RW = $clog2(RING_ROWS);
  localparam int DW = CW + 1;
  localparam int PW = RW + srrm_pkg::LW_W;

  logic [srrm_pkg::VIS_W-1:0]  vis_cfg_r;
  logic [srrm_pkg::HLIM_W-1:0] hlim_cfg_r;
  logic [srrm_pkg::LW_W-1:0]   lw_cfg_r;

  logic [CW-1:0] vis_r, hist_r, cap_r;
  logic [RW-1:0] head_r, head_nxt;
  logic [CW-1:0] hc_r, hc_nxt;
  logic [CW-1:0] sc_r, sc_nxt;

  logic [srrm_pkg::MODE_W-1:0]  mode_r;
  logic [srrm_pkg::DELTA_W-1:0] delta_r;
  logic [srrm_pkg::SROW_W-1:0]  row_r;

  logic [RW-1:0]                 ring_r, ring_nxt;
  logic [srrm_pkg::OCNT_W-1:0]   oview_r, ohist_r;
  logic [srrm_pkg::CODE_W-1:0]   owipe_r, owipe_nxt, ostat_r, ostat_nxt;
  logic [srrm_pkg::CELL_W-1:0]   ocell_r;

  logic [CW-1:0] g_vis, g_room, g_hist, g_cap;
  logic [CW-1:0] hc_f, sc_f;
  logic [RW-1:0] head_f;

  logic          grow;
  logic [CW-1:0] hc_p, sc_inc;
  logic [DW-1:0] inc, sum, logical, lsum;
  logic [RW-1:0] head_p;
  logic [srrm_pkg::DELTA_W-1:0] room32, dec;
  logic [CW-1:0] room;
  logic [PW-1:0] prod;

  always_comb begin
    g_vis  = (32'(vis_cfg_r) >= 32'(RING_ROWS)) ? CW'(RING_ROWS) : CW'(vis_cfg_r);
    g_room = CW'(RING_ROWS) - g_vis;
    g_hist = (32'(hlim_cfg_r) >= 32'(g_room)) ? g_room : CW'(hlim_cfg_r);
    g_cap  = g_vis + g_hist;
    hc_f   = (hc_r > g_hist) ? g_hist : hc_r;
    sc_f   = (sc_r > hc_f) ? hc_f : sc_r;
    head_f = (CW'(head_r) >= g_cap) ? '0 : head_r;
  end

  always_comb begin
    grow   = (hc_r < hist_r);
    hc_p   = grow ? hc_r + CW'(1) : hc_r;
    inc    = DW'(head_r) + DW'(1);
    head_p = grow ? head_r : RW'((inc >= DW'(cap_r)) ? inc - DW'(cap_r) : inc);
    sum    = DW'(head_p) + DW'(hc_p) + DW'(vis_r) - DW'(1);
    sc_inc = sc_r + CW'(1);
    room   = hc_r - sc_r;
    room32 = 32'(room);
    dec    = 32'd0 - delta_r;
    logical = DW'(hc_r) + DW'(row_r) - ((mode_r == srrm_pkg::MODE_REND) ? DW'(sc_r) : DW'(0));
    lsum    = DW'(head_r) + logical;

    head_nxt  = head_r;
    hc_nxt    = hc_r;
    sc_nxt    = sc_r;
    ring_nxt  = '0;
    owipe_nxt = srrm_pkg::WIPE_NONE;
    ostat_nxt = srrm_pkg::STAT_DONE;
    case (mode_r)
      srrm_pkg::MODE_PUSH: begin
        if (vis_r == '0) begin
          ostat_nxt = srrm_pkg::STAT_NOVIS;
        end else begin
          head_nxt  = head_p;
          hc_nxt    = hc_p;
          ring_nxt  = RW'((sum >= DW'(cap_r)) ? sum - DW'(cap_r) : sum);
          owipe_nxt = srrm_pkg::WIPE_ROW;
          if (sc_r != '0) begin
            sc_nxt = (sc_inc > hc_p) ? hc_p : sc_inc;
          end
        end
      end
      srrm_pkg::MODE_SCROLL: begin
        if (!delta_r[srrm_pkg::DELTA_W-1]) begin
          sc_nxt = (delta_r >= room32) ? hc_r : sc_r + CW'(delta_r);
        end else begin
          sc_nxt = (32'(sc_r) > dec) ? sc_r - CW'(dec) : '0;
        end
      end
      srrm_pkg::MODE_LIVE, srrm_pkg::MODE_REND: begin
        if (32'(row_r) >= 32'(vis_r)) begin
          ostat_nxt = srrm_pkg::STAT_RANGE;
        end else begin
          ring_nxt = RW'((lsum >= DW'(cap_r)) ? lsum - DW'(cap_r) : lsum);
        end
      end
      srrm_pkg::MODE_CLEAR: begin
        head_nxt  = '0;
        hc_nxt    = '0;
        sc_nxt    = '0;
        owipe_nxt = srrm_pkg::WIPE_STORE;
      end
      default: begin
        ostat_nxt = srrm_pkg::STAT_DONE;
      end
    endcase
  end

  assign prod = PW'(ring_r) * PW'(lw_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_cfg_r  <= srrm_pkg::VIS_RST;
      hlim_cfg_r <= srrm_pkg::HLIM_RST;
      lw_cfg_r   <= srrm_pkg::LW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srrm_pkg::REG_VIS:  vis_cfg_r  <= cfg_data[srrm_pkg::VIS_W-1:0];
        srrm_pkg::REG_HLIM: hlim_cfg_r <= cfg_data[srrm_pkg::HLIM_W-1:0];
        srrm_pkg::REG_LW:   lw_cfg_r   <= cfg_data[srrm_pkg::LW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      hc_r   <= '0;
      sc_r   <= '0;
    end else if (cmd.fit) begin
      head_r <= head_f;
      hc_r   <= hc_f;
      sc_r   <= sc_f;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      hc_r   <= hc_nxt;
      sc_r   <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fit) begin
      vis_r  <= g_vis;
      hist_r <= g_hist;
      cap_r  <= g_cap;
    end
    if (cmd.capture) begin
      mode_r  <= in_mode;
      delta_r <= in_scroll_delta;
      row_r   <= in_screen_row;
    end
    if (cmd.exec) begin
      ring_r  <= ring_nxt;
      oview_r <= srrm_pkg::OCNT_W'(sc_nxt);
      ohist_r <= srrm_pkg::OCNT_W'(hc_nxt);
      owipe_r <= owipe_nxt;
      ostat_r <= ostat_nxt;
    end
    if (cmd.mult) begin
      ocell_r <= srrm_pkg::CELL_W'(prod);
    end
  end

  assign out_ring_row      = srrm_pkg::OROW_W'(ring_r);
  assign out_cell_base     = ocell_r;
  assign out_view_offset   = oview_r;
  assign out_history_lines = ohist_r;
  assign out_wipe          = owipe_r;
  assign out_status        = ostat_r;

endmodule

### src/scrollback_ring_row_mapper_unit.sv
// ----------------------------------------------------------------------------
// scrollback_ring_row_mapper_unit
// Line ring mapper of a terminal with scrollback: push, scroll, locate, clear.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result is
// driven for exactly one cycle with out_valid, which is registered from the
// multiply state, and busy drops in that same cycle unless a configuration
// write is pending, so a new transaction can be taken while the last result is
// driven. The steps are capture, counter update with compare-subtract wrap,
// then the row-times-width multiply. The receiver cannot stall; take each
// result in its strobe cycle. Every configuration write holds busy while the
// counters are fitted to the new geometry, and so does reset.
module scrollback_ring_row_mapper_unit #(
  parameter int RING_ROWS = srrm_pkg::RING_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [srrm_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [srrm_pkg::DELTA_W-1:0] in_scroll_delta,
  input  logic [srrm_pkg::SROW_W-1:0]         in_screen_row,
  output logic                                out_valid,
  output logic [srrm_pkg::OROW_W-1:0]         out_ring_row,
  output logic [srrm_pkg::CELL_W-1:0]         out_cell_base,
  output logic [srrm_pkg::OCNT_W-1:0]         out_view_offset,
  output logic [srrm_pkg::OCNT_W-1:0]         out_history_lines,
  output logic [srrm_pkg::CODE_W-1:0]         out_wipe,
  output logic [srrm_pkg::CODE_W-1:0]         out_status,
  input  logic                                cfg_we,
  input  logic [srrm_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [srrm_pkg::CFG_W-1:0]          cfg_data
);

  srrm_pkg::srrm_cmd_t cmd;

  srrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_we    (cfg_we),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  srrm_datapath #(
    .RING_ROWS (RING_ROWS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_mode           (in_mode),
    .in_scroll_delta   (in_scroll_delta),
    .in_screen_row     (in_screen_row),
    .out_ring_row      (out_ring_row),
    .out_cell_base     (out_cell_base),
    .out_view_offset   (out_view_offset),
    .out_history_lines (out_history_lines),
    .out_wipe          (out_wipe),
    .out_status        (out_status)
  );

endmodule
